FILE: rtl/hadf_pkg.sv
package hadf_pkg;

    localparam int BYTES_PER_LINE = 16;
    localparam int COL_W          = $clog2(BYTES_PER_LINE);

    localparam logic [COL_W-1:0] LAST_COL = COL_W'(BYTES_PER_LINE - 1);

    // Character source select for the output register.
    localparam logic [2:0] SEL_HI  = 3'd0;
    localparam logic [2:0] SEL_LO  = 3'd1;
    localparam logic [2:0] SEL_SP  = 3'd2;
    localparam logic [2:0] SEL_CHR = 3'd3;
    localparam logic [2:0] SEL_NL  = 3'd4;

    localparam logic [6:0] CH_SPACE   = 7'd32;
    localparam logic [6:0] CH_PERIOD  = 7'd46;
    localparam logic [6:0] CH_NEWLINE = 7'd10;
    localparam logic [6:0] CH_ZERO    = 7'd48;
    localparam logic [6:0] CH_A_LOW   = 7'd97;
    localparam logic [7:0] PRINT_LO   = 8'd32;
    localparam logic [7:0] PRINT_HI   = 8'd126;

    typedef struct packed {
        logic            in_ready;
        logic            emit;
        logic [2:0]      sel;
        logic            last;
        logic            idx_pad;   // start padding at the column after the current one
        logic            idx_zero;
        logic            idx_inc;
        logic            sub_clr;
        logic            sub_inc;
    } hadf_cmd_t;

    typedef struct packed {
        logic accept;
        logic out_free;
        logic odd;          // current byte sits in an odd column
        logic close;        // current byte ends the line
        logic cur_last;     // current byte is in the final column
        logic idx_last;     // index counter is at the final column
        logic idx_at_cur;   // index counter has reached the current column
        logic sub_done;     // last space of the padded column
    } hadf_stat_t;

    function automatic logic [6:0] hex_char(input logic [3:0] nib);
        if (nib < 4'd10)
            hex_char = CH_ZERO + {3'd0, nib};
        else
            hex_char = CH_A_LOW + {3'd0, nib} - 7'd10;
    endfunction

    function automatic logic [6:0] shown_char(input logic [7:0] b);
        if (b >= PRINT_LO && b <= PRINT_HI)
            shown_char = b[6:0];
        else
            shown_char = CH_PERIOD;
    endfunction

endpackage

FILE: rtl/hadf_in_if.sv
interface hadf_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       final_byte;

    modport source (output valid, output data_byte, output final_byte, input ready);
    modport sink   (input valid, input data_byte, input final_byte, output ready);
endinterface

FILE: rtl/hadf_out_if.sv
interface hadf_out_if;
    logic       valid;
    logic       ready;
    logic [6:0] out_char;
    logic       last_of_run;

    modport source (output valid, output out_char, output last_of_run, input ready);
    modport sink   (input valid, input out_char, input last_of_run, output ready);
endinterface

FILE: rtl/hex_ascii_dump_formatter_core.sv
// Hex dump formatter, 16 bytes per line; one output character per cycle unless stalled.
// The first hex digit of an accepted byte passes the HI state, then the output register.
// A new input byte is taken only after every character of the previous byte has been
// emitted; the controller emits characters through a single output register.
// Reset (rst_n, asynchronous, active low) returns to column 0 with no output pending;
// the line store is not cleared, since only columns written in the current line are read.
module hex_ascii_dump_formatter_core (
    input  logic       clk,
    input  logic       rst_n,
    hadf_in_if.sink    in_stream,
    hadf_out_if.source out_stream
);

    hadf_pkg::hadf_cmd_t  cmd;
    hadf_pkg::hadf_stat_t st;

    hadf_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .st    (st),
        .cmd   (cmd)
    );

    hadf_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_stream  (in_stream),
        .out_stream (out_stream),
        .cmd        (cmd),
        .st         (st)
    );

endmodule

FILE: rtl/hadf_ctrl.sv
module hadf_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  hadf_pkg::hadf_stat_t st,
    output hadf_pkg::hadf_cmd_t  cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_HI   = 3'd1;
    localparam logic [2:0] S_LO   = 3'd2;
    localparam logic [2:0] S_SP   = 3'd3;
    localparam logic [2:0] S_PAD  = 3'd4;
    localparam logic [2:0] S_CHR  = 3'd5;
    localparam logic [2:0] S_NL   = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic [2:0] close_state;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // After the hex text of a closing byte: pad unless the line is full.
    always_comb
    begin
        close_state = st.cur_last ? S_CHR : S_PAD;
    end

    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        cmd.sel      = hadf_pkg::SEL_HI;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.in_ready = 1'b1;
                if (st.accept)
                    state_next = S_HI;
            end
            S_HI:
            begin
                if (st.out_free)
                begin
                    cmd.emit   = 1'b1;
                    cmd.sel    = hadf_pkg::SEL_HI;
                    state_next = S_LO;
                end
            end
            S_LO:
            begin
                if (st.out_free)
                begin
                    cmd.emit = 1'b1;
                    cmd.sel  = hadf_pkg::SEL_LO;
                    cmd.last = !st.odd && !st.close;
                    if (st.odd)
                        state_next = S_SP;
                    else if (st.close)
                    begin
                        state_next   = close_state;
                        cmd.idx_pad  = !st.cur_last;
                        cmd.idx_zero = st.cur_last;
                        cmd.sub_clr  = 1'b1;
                    end
                    else
                        state_next = S_IDLE;
                end
            end
            S_SP:
            begin
                if (st.out_free)
                begin
                    cmd.emit = 1'b1;
                    cmd.sel  = hadf_pkg::SEL_SP;
                    cmd.last = !st.close;
                    if (st.close)
                    begin
                        state_next   = close_state;
                        cmd.idx_pad  = !st.cur_last;
                        cmd.idx_zero = st.cur_last;
                        cmd.sub_clr  = 1'b1;
                    end
                    else
                        state_next = S_IDLE;
                end
            end
            S_PAD:
            begin
                if (st.out_free)
                begin
                    cmd.emit = 1'b1;
                    cmd.sel  = hadf_pkg::SEL_SP;
                    if (st.sub_done)
                    begin
                        cmd.sub_clr = 1'b1;
                        if (st.idx_last)
                        begin
                            cmd.idx_zero = 1'b1;
                            state_next   = S_CHR;
                        end
                        else
                            cmd.idx_inc = 1'b1;
                    end
                    else
                        cmd.sub_inc = 1'b1;
                end
            end
            S_CHR:
            begin
                if (st.out_free)
                begin
                    cmd.emit = 1'b1;
                    cmd.sel  = hadf_pkg::SEL_CHR;
                    if (st.idx_at_cur)
                        state_next = S_NL;
                    else
                        cmd.idx_inc = 1'b1;
                end
            end
            S_NL:
            begin
                if (st.out_free)
                begin
                    cmd.emit   = 1'b1;
                    cmd.sel    = hadf_pkg::SEL_NL;
                    cmd.last   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/hadf_dp.sv
module hadf_dp (
    input  logic                 clk,
    input  logic                 rst_n,
    hadf_in_if.sink              in_stream,
    hadf_out_if.source           out_stream,
    input  hadf_pkg::hadf_cmd_t  cmd,
    output hadf_pkg::hadf_stat_t st
);

    logic [7:0]                    line_store_reg [hadf_pkg::BYTES_PER_LINE];
    logic [7:0]                    byte_reg;
    logic                          fin_reg;
    logic [hadf_pkg::COL_W-1:0]    col_reg;
    logic [hadf_pkg::COL_W-1:0]    col_next;
    logic [hadf_pkg::COL_W-1:0]    cur_col_reg;
    logic [hadf_pkg::COL_W-1:0]    idx_reg;
    logic [hadf_pkg::COL_W-1:0]    idx_next;
    logic [1:0]                    sub_reg;
    logic [1:0]                    sub_next;
    logic                          out_valid_reg;
    logic [6:0]                    out_char_reg;
    logic                          out_last_reg;
    logic [6:0]                    char_sel;
    logic                          accept;
    logic                          in_close;

    assign in_stream.ready     = cmd.in_ready;
    assign accept              = in_stream.valid && cmd.in_ready;
    assign in_close            = in_stream.final_byte || (col_reg == hadf_pkg::LAST_COL);

    assign out_stream.valid       = out_valid_reg;
    assign out_stream.out_char    = out_char_reg;
    assign out_stream.last_of_run = out_last_reg;

    always_comb
    begin
        st            = '0;
        st.accept     = accept;
        st.out_free   = !out_valid_reg || out_stream.ready;
        st.odd        = cur_col_reg[0];
        st.close      = fin_reg || (cur_col_reg == hadf_pkg::LAST_COL);
        st.cur_last   = (cur_col_reg == hadf_pkg::LAST_COL);
        st.idx_last   = (idx_reg == hadf_pkg::LAST_COL);
        st.idx_at_cur = (idx_reg == cur_col_reg);
        // Odd padded columns take a third space.
        st.sub_done   = (sub_reg == 2'd2) || (sub_reg == 2'd1 && !idx_reg[0]);
    end

    always_comb
    begin
        col_next = col_reg;
        if (accept)
            col_next = in_close ? '0 : col_reg + 1'b1;
    end

    always_comb
    begin
        idx_next = idx_reg;
        if (cmd.idx_pad)
            idx_next = cur_col_reg + 1'b1;
        else if (cmd.idx_zero)
            idx_next = '0;
        else if (cmd.idx_inc)
            idx_next = idx_reg + 1'b1;
    end

    always_comb
    begin
        sub_next = sub_reg;
        if (cmd.sub_clr)
            sub_next = '0;
        else if (cmd.sub_inc)
            sub_next = sub_reg + 1'b1;
    end

    always_comb
    begin
        case (cmd.sel)
            hadf_pkg::SEL_HI:  char_sel = hadf_pkg::hex_char(byte_reg[7:4]);
            hadf_pkg::SEL_LO:  char_sel = hadf_pkg::hex_char(byte_reg[3:0]);
            hadf_pkg::SEL_SP:  char_sel = hadf_pkg::CH_SPACE;
            hadf_pkg::SEL_CHR: char_sel = hadf_pkg::shown_char(line_store_reg[idx_reg]);
            hadf_pkg::SEL_NL:  char_sel = hadf_pkg::CH_NEWLINE;
            default:           char_sel = hadf_pkg::CH_SPACE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            idx_reg       <= '0;
            sub_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            col_reg <= col_next;
            idx_reg <= idx_next;
            sub_reg <= sub_next;
            if (cmd.emit)
                out_valid_reg <= 1'b1;
            else if (out_stream.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            byte_reg                <= in_stream.data_byte;
            fin_reg                 <= in_stream.final_byte;
            cur_col_reg             <= col_reg;
            line_store_reg[col_reg] <= in_stream.data_byte;
        end
        if (cmd.emit)
        begin
            out_char_reg <= char_sel;
            out_last_reg <= cmd.last;
        end
    end

endmodule

FILE: tb/hex_ascii_dump_formatter_core_tb.sv
`timescale 1ns / 1ps

module hex_ascii_dump_formatter_core_tb;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int BYTE_TARGET  = 370;
    localparam int HOLD_AFTER   = 150;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 20;

    typedef struct {
        logic [7:0] data;
        logic       fin;
    } dump_byte_t;

    typedef struct {
        logic [6:0] ch;
        logic       last;
    } dump_char_t;

    typedef enum {RX_ALWAYS, RX_RANDOM, RX_PATTERN} rx_mode_t;

    logic clk;
    logic rst_n;

    hadf_in_if  in_bus();
    hadf_out_if out_bus();

    hex_ascii_dump_formatter_core uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_stream  (in_bus),
        .out_stream (out_bus)
    );

    dump_byte_t byte_queue[$];
    dump_char_t dump_text_q[$];

    // Predicted state of the current dump line.
    logic [7:0] line_bytes [0:hadf_pkg::BYTES_PER_LINE-1];
    int         line_col;

    int          error_count;
    int          bytes_taken;
    int          bytes_total;
    int unsigned cycle_count;

    int         burst_left;
    int         gap_left;
    dump_byte_t next_byte;

    rx_mode_t   rx_mode;
    int         rx_phase_left;
    int         hold_left;
    logic       hold_done;
    logic [7:0] rx_pattern;
    dump_char_t want;

    logic [7:0] edge_bytes [0:15] = '{
        8'h1f, 8'h20, 8'h7e, 8'h7f, 8'h80, 8'h00, 8'hff, 8'h41,
        8'h5a, 8'h61, 8'h7a, 8'h30, 8'h39, 8'h0a, 8'h2e, 8'ha5
    };

    // The clock starts low so that no rising edge falls in the first time step.
    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    function automatic logic [6:0] hex_ascii(input logic [3:0] nib);
        if (nib < 4'd10)
            return 7'h30 + 7'(nib);
        return 7'h61 + 7'(nib) - 7'd10;
    endfunction

    // Appends the dump text that one accepted byte produces.
    function automatic void format_byte(input logic [7:0] b, input logic fin);
        logic [6:0] text[$];
        int         col;
        int         c;
        dump_char_t item;

        col = line_col;
        text.push_back(hex_ascii(b[7:4]));
        text.push_back(hex_ascii(b[3:0]));
        if (col % 2 == 1)
            text.push_back(hadf_pkg::CH_SPACE);
        line_bytes[col] = b;
        col++;
        if (col >= hadf_pkg::BYTES_PER_LINE || fin)
        begin
            for (c = col; c < hadf_pkg::BYTES_PER_LINE; c++)
            begin
                text.push_back(hadf_pkg::CH_SPACE);
                text.push_back(hadf_pkg::CH_SPACE);
                if (c % 2 == 1)
                    text.push_back(hadf_pkg::CH_SPACE);
            end
            for (c = 0; c < col; c++)
            begin
                if (line_bytes[c] >= 8'd32 && line_bytes[c] <= 8'd126)
                    text.push_back(line_bytes[c][6:0]);
                else
                    text.push_back(hadf_pkg::CH_PERIOD);
            end
            text.push_back(hadf_pkg::CH_NEWLINE);
            col = 0;
        end
        line_col = col;
        for (c = 0; c < text.size(); c++)
        begin
            item.ch   = text[c];
            item.last = (c == text.size() - 1);
            dump_text_q.push_back(item);
        end
    endfunction

    function automatic void queue_byte(input logic [7:0] b, input logic fin);
        dump_byte_t item;

        item.data = b;
        item.fin  = fin;
        byte_queue.push_back(item);
    endfunction

    // A run of random bytes, optionally closed by a final byte.
    function automatic void queue_region(input int count, input logic close);
        logic [7:0] b;

        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 3) == 0)
                b = edge_bytes[$urandom_range(0, 15)];
            else
                b = 8'($urandom_range(0, 255));
            queue_byte(b, close && (i == count - 1));
        end
    endfunction

    task automatic report_mismatch(input string msg);
        error_count++;
        $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    // Sender: bursts of random length separated by random gaps.
    always @(posedge clk)
    begin
        if (!rst_n)
            in_bus.valid <= 1'b0;
        else if (!in_bus.valid || in_bus.ready)
        begin
            if (gap_left > 0)
            begin
                gap_left <= gap_left - 1;
                in_bus.valid <= 1'b0;
            end
            else if (byte_queue.size() != 0)
            begin
                next_byte = byte_queue.pop_front();
                in_bus.valid      <= 1'b1;
                in_bus.data_byte  <= next_byte.data;
                in_bus.final_byte <= next_byte.fin;
                if (burst_left > 1)
                    burst_left <= burst_left - 1;
                else
                begin
                    burst_left <= ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                                              : $urandom_range(1, 10);
                    gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
            else
                in_bus.valid <= 1'b0;
        end
    end

    // One long hold-off on the output side, so the block backs up into its input.
    always @(posedge clk)
    begin
        if (!hold_done && bytes_taken >= HOLD_AFTER)
        begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
        else if (hold_left > 0)
            hold_left <= hold_left - 1;
    end

    // Receiver: stall behavior changes from phase to phase.
    always @(posedge clk)
    begin
        if (rx_phase_left == 0)
        begin
            rx_mode       <= rx_mode_t'($urandom_range(0, 2));
            rx_phase_left <= $urandom_range(20, 120);
        end
        else
            rx_phase_left <= rx_phase_left - 1;
        rx_pattern <= {rx_pattern[6:0], rx_pattern[7]};
        if (hold_left > 0)
            out_bus.ready <= 1'b0;
        else
        begin
            case (rx_mode)
                RX_ALWAYS:  out_bus.ready <= 1'b1;
                RX_RANDOM:  out_bus.ready <= 1'($urandom_range(0, 1));
                RX_PATTERN: out_bus.ready <= rx_pattern[0];
                default:    out_bus.ready <= 1'b1;
            endcase
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && in_bus.valid && in_bus.ready)
        begin
            format_byte(in_bus.data_byte, in_bus.final_byte);
            bytes_taken <= bytes_taken + 1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_bus.valid && out_bus.ready)
        begin
            if (dump_text_q.size() == 0)
                report_mismatch($sformatf("unexpected character %0d (last %0b)",
                                          out_bus.out_char, out_bus.last_of_run));
            else
            begin
                want = dump_text_q.pop_front();
                if (out_bus.out_char !== want.ch)
                    report_mismatch($sformatf("out_char %0d, expected %0d",
                                              out_bus.out_char, want.ch));
                if (out_bus.last_of_run !== want.last)
                    report_mismatch($sformatf("last_of_run %0b, expected %0b on char %0d",
                                              out_bus.last_of_run, want.last, want.ch));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial
    begin
        int kind;

        rst_n             = 1'b0;
        in_bus.valid      = 1'b0;
        in_bus.data_byte  = 8'h00;
        in_bus.final_byte = 1'b0;
        out_bus.ready     = 1'b0;
        error_count       = 0;
        bytes_taken       = 0;
        cycle_count       = 0;
        line_col          = 0;
        burst_left        = 1;
        gap_left          = 0;
        rx_mode           = RX_ALWAYS;
        rx_phase_left     = 40;
        hold_left         = 0;
        hold_done         = 1'b0;
        rx_pattern        = 8'b1011_0010;

        // Final byte in column 0 gives the longest line of padding.
        queue_byte(8'h00, 1'b1);
        queue_byte(8'hff, 1'b1);
        // A full line of printable boundaries and non-printables.
        for (int i = 0; i < 16; i++)
            queue_byte(edge_bytes[i], 1'b0);
        // Final byte in an odd column.
        queue_byte(8'h3c, 1'b0);
        queue_byte(8'hc3, 1'b1);

        while (byte_queue.size() < BYTE_TARGET)
        begin
            kind = $urandom_range(0, 9);
            if (kind <= 5)
                queue_region($urandom_range(1, 16), 1'b1);
            else if (kind == 6)
                queue_region(hadf_pkg::BYTES_PER_LINE, 1'b1);
            else if (kind <= 8)
                queue_region($urandom_range(17, 48), 1'b1);
            else
                queue_region($urandom_range(1, 4), 1'b0);
        end
        queue_byte(8'h7e, 1'b1);
        bytes_total = byte_queue.size();

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        while (bytes_taken != bytes_total)
            @(posedge clk);
        while (dump_text_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
